// File: rtl/vfv_pkg.sv
package vfv_pkg;

   // Request and response layouts.
   localparam int POS_W      = 5;
   localparam int COLOR_W    = 8;
   localparam int FACES      = 6;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 64;

   // Configuration registers.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int SIZE_W      = 6;
   localparam int EMIS_W      = 64;
   localparam int EMIS_REGS   = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_SIZE_X = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SIZE_Y = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SIZE_Z = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_EMIS_0 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_EMIS_1 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_EMIS_2 = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_EMIS_3 = 3'd6;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Extent compares are done at a width that covers the largest grid.
   localparam int DIM_W = 9;
   // Neighbour coordinates run from -1 to 32.
   localparam int CRD_W = 7;

   // Chunk id: three 10-bit fields.
   localparam int CHUNK_FIELD_W = 10;
   localparam int CHUNK_ID_W    = 30;

   // Read sequence: the centre voxel first, then one neighbour per face bit.
   localparam int STEPS   = 7;
   localparam int STEP_W  = 3;
   localparam logic [STEP_W-1:0] STEP_CENTRE = 3'd0;
   localparam logic [STEP_W-1:0] STEP_LAST   = 3'd6;

   localparam logic signed [1:0] NB_DX [STEPS] = '{2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0};
   localparam logic signed [1:0] NB_DY [STEPS] = '{2'sd0, 2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd0};
   localparam logic signed [1:0] NB_DZ [STEPS] = '{2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1, -2'sd1};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

endpackage

// File: rtl/voxel_face_visibility_core.sv
// Voxel grid of 8-bit colour indices (0 is air) held in one single-port synchronous memory
// of MAX_DIM^3 entries. A write request (tuser low) stores one voxel in the cycle it is
// accepted and gives no response; a voxel outside the configured extent is not stored. A
// query request (tuser high) gives one response with the voxel's solid flag, colour,
// visible-face mask, emissive flag and chunk coordinates. The block is busy with it from
// acceptance through the reads of the centre voxel and its six neighbours through the one
// memory port, the last read data and the load of the response register. The next request
// is taken while a response still waits to be taken. Voxels that were never written read
// back as undefined; the memory has no clearing pass.
module voxel_face_visibility_core #(
   parameter int MAX_DIM    = 32,
   parameter int CHUNK_EDGE = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pos_x[4:0], pos_y[9:5], pos_z[14:10], color_in[22:15], zero[23]
   input  logic [vfv_pkg::REQ_DATA_W-1:0]      req_tdata,
   // op
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // solid[0], color_out[8:1], face_mask[14:9], emissive[15], chunk_x[20:16],
   // chunk_y[25:21], chunk_z[30:26], chunk_id[60:31], zero[63:61]
   output logic [vfv_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_we,
   input  logic [vfv_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [vfv_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import vfv_pkg::*;

   localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(DEPTH);

   // Configuration.
   logic [SIZE_W-1:0] size_x_ff, size_y_ff, size_z_ff;
   logic [EMIS_W-1:0] emis_ff [EMIS_REGS];

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_RESET;
         size_y_ff <= SIZE_RESET;
         size_z_ff <= SIZE_RESET;
         for (int i = 0; i < EMIS_REGS; i++) emis_ff[i] <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_SIZE_X: size_x_ff <= csr_wdata[SIZE_W-1:0];
            REG_SIZE_Y: size_y_ff <= csr_wdata[SIZE_W-1:0];
            REG_SIZE_Z: size_z_ff <= csr_wdata[SIZE_W-1:0];
            REG_EMIS_0: emis_ff[0] <= csr_wdata;
            REG_EMIS_1: emis_ff[1] <= csr_wdata;
            REG_EMIS_2: emis_ff[2] <= csr_wdata;
            REG_EMIS_3: emis_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective extent is the configured size capped at the memory's dimension.
   logic [DIM_W-1:0] ext_x, ext_y, ext_z;

   function automatic logic [DIM_W-1:0] cap_size(input logic [SIZE_W-1:0] s);
      logic [DIM_W-1:0] sw;
      sw = DIM_W'(s);
      return (sw > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : sw;
   endfunction

   assign ext_x = cap_size(size_x_ff);
   assign ext_y = cap_size(size_y_ff);
   assign ext_z = cap_size(size_z_ff);

   function automatic logic in_grid(input logic signed [CRD_W-1:0] x,
                                    input logic signed [CRD_W-1:0] y,
                                    input logic signed [CRD_W-1:0] z,
                                    input logic [DIM_W-1:0] ex,
                                    input logic [DIM_W-1:0] ey,
                                    input logic [DIM_W-1:0] ez);
      return (x >= 0) && (y >= 0) && (z >= 0) &&
             (DIM_W'($unsigned(x)) < ex) &&
             (DIM_W'($unsigned(y)) < ey) &&
             (DIM_W'($unsigned(z)) < ez);
   endfunction

   // Only meaningful for coordinates inside the grid, which are below MAX_DIM.
   function automatic logic [AW-1:0] cell_addr(input logic signed [CRD_W-1:0] x,
                                               input logic signed [CRD_W-1:0] y,
                                               input logic signed [CRD_W-1:0] z);
      return AW'($unsigned(x)) + AW'($unsigned(y)) * AW'(MAX_DIM) +
             AW'($unsigned(z)) * AW'(MAX_DIM * MAX_DIM);
   endfunction

   // Chunk coordinate of each position, worked out at elaboration.
   logic [POS_W-1:0] chunk_lut [2**POS_W];
   for (genvar g = 0; g < 2**POS_W; g++) begin : g_chunk
      assign chunk_lut[g] = POS_W'(g / CHUNK_EDGE);
   end

   // Request fields.
   logic [POS_W-1:0]   req_x, req_y, req_z;
   logic [COLOR_W-1:0] req_color;
   logic               req_fire;

   assign req_x     = req_tdata[POS_W-1:0];
   assign req_y     = req_tdata[2*POS_W-1:POS_W];
   assign req_z     = req_tdata[3*POS_W-1:2*POS_W];
   assign req_color = req_tdata[3*POS_W+COLOR_W-1:3*POS_W];
   assign req_fire  = req_tvalid && req_tready;

   // Control.
   state_type state_ff, state_in;
   logic      scan_issue, load_rsp;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_fire && req_tuser == OP_QUERY) state_in = ST_SCAN;
         ST_SCAN:   if (step_ff == STEP_LAST) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = ST_FINISH;
         ST_FINISH: if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      scan_issue = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_SCAN:   scan_issue = 1'b1;
         ST_FINISH: load_rsp   = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   assign step_in = (state_ff == ST_SCAN && step_ff != STEP_LAST) ? step_ff + 1'b1
                                                                  : STEP_CENTRE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_CENTRE;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Query position, held for the whole read sequence.
   logic [POS_W-1:0] qx_ff, qy_ff, qz_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         qx_ff <= req_x;
         qy_ff <= req_y;
         qz_ff <= req_z;
      end
   end

   // Coordinates of the voxel read in this step.
   logic signed [CRD_W-1:0] nb_x, nb_y, nb_z;
   logic                    nb_in;

   assign nb_x  = $signed(CRD_W'(qx_ff)) + CRD_W'(NB_DX[step_ff]);
   assign nb_y  = $signed(CRD_W'(qy_ff)) + CRD_W'(NB_DY[step_ff]);
   assign nb_z  = $signed(CRD_W'(qz_ff)) + CRD_W'(NB_DZ[step_ff]);
   assign nb_in = in_grid(nb_x, nb_y, nb_z, ext_x, ext_y, ext_z);

   // Write side, taken in the cycle of acceptance.
   logic signed [CRD_W-1:0] wr_x, wr_y, wr_z;
   logic                    mem_we;
   logic [AW-1:0]           mem_addr;

   assign wr_x   = $signed(CRD_W'(req_x));
   assign wr_y   = $signed(CRD_W'(req_y));
   assign wr_z   = $signed(CRD_W'(req_z));
   assign mem_we = req_fire && req_tuser == OP_WRITE &&
                   in_grid(wr_x, wr_y, wr_z, ext_x, ext_y, ext_z);
   assign mem_addr = scan_issue ? cell_addr(nb_x, nb_y, nb_z) : cell_addr(wr_x, wr_y, wr_z);

   // Voxel memory: one port, registered read.
   logic [COLOR_W-1:0] voxel_mem [DEPTH];
   logic [COLOR_W-1:0] mem_q_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         voxel_mem[mem_addr] <= req_color;
      end else begin
         mem_q_ff <= voxel_mem[mem_addr];
      end
   end

   // Read data arrives in the cycle after the address; track what it belongs to.
   logic              rd_valid_ff, rd_in_ff;
   logic [STEP_W-1:0] rd_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= scan_issue;
      end
      rd_step_ff <= step_ff;
      rd_in_ff   <= nb_in;
   end

   // Accumulate the centre colour and the face mask.
   logic [COLOR_W-1:0] color_ff, color_in;
   logic [FACES-1:0]   mask_ff, mask_in;

   always_comb begin
      color_in = color_ff;
      mask_in  = mask_ff;
      if (req_fire) begin
         mask_in = '1;
      end else if (rd_valid_ff) begin
         if (rd_step_ff == STEP_CENTRE) begin
            color_in = rd_in_ff ? mem_q_ff : '0;
         end
         for (int f = 0; f < FACES; f++) begin
            if (rd_step_ff == STEP_W'(f + 1) && rd_in_ff && mem_q_ff != '0) begin
               mask_in[f] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      color_ff <= color_in;
      mask_ff  <= mask_in;
   end

   // Response register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  emissive;
   logic [POS_W-1:0]      cx, cy, cz;
   logic [CHUNK_ID_W-1:0] chunk_id;

   assign emissive = (color_ff != '0) && emis_ff[color_ff[7:6]][color_ff[5:0]];
   assign cx = chunk_lut[qx_ff];
   assign cy = chunk_lut[qy_ff];
   assign cz = chunk_lut[qz_ff];
   assign chunk_id = {CHUNK_FIELD_W'(cz), CHUNK_FIELD_W'(cy), CHUNK_FIELD_W'(cx)};

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'({chunk_id, cz, cy, cx, emissive, mask_ff, color_ff,
                                     color_ff != '0});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/vfv_checker.sv
module vfv_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [vfv_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import vfv_pkg::*;

   // A stalled response holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // Reset leaves no response pending.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response pending after reset");

   // Solid follows the colour, and only a solid voxel can be emissive.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[8:1] != 8'd0)) &&
                     (!rsp_tdata[15] || rsp_tdata[0]))
      else $error("solid or emissive flag inconsistent with colour");

   // The packed chunk id carries the same chunk coordinates.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[35:31] == rsp_tdata[20:16] &&
                     rsp_tdata[45:41] == rsp_tdata[25:21] &&
                     rsp_tdata[55:51] == rsp_tdata[30:26] &&
                     rsp_tdata[40:36] == 5'd0 && rsp_tdata[50:46] == 5'd0 &&
                     rsp_tdata[63:56] == 8'd0)
      else $error("chunk id does not match chunk coordinates");

endmodule

bind voxel_face_visibility_core vfv_checker u_vfv_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
